// ===== rtl/core/lnl_pkg.sv =====
// ----------------------------------------------------------------------------
// lnl_pkg
// Types and constants shared by the LIF neuron layer core.
// ----------------------------------------------------------------------------
package lnl_pkg;

	localparam int SPIKE_IN_W  = 8;
	localparam int SPIKE_OUT_W = 2;
	localparam int WADDR_W     = 4;
	localparam int POT_W       = 16;
	localparam int DECAY_W     = 8;
	localparam int REFR_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 8;
	// synaptic sum of up to SPIKE_IN_W weights
	localparam int SUM_W       = POT_W + 3;
	localparam int ACC_W       = POT_W + 4;
	localparam int WT_MAX      = 1 << WADDR_W;

	localparam logic [DECAY_W-1:0]     DECAY_RST = 8'd230;
	localparam logic signed [POT_W-1:0] THR_RST  = 16'sd256;
	localparam logic signed [POT_W-1:0] REST_RST = 16'sd0;
	localparam logic [REFR_W-1:0]      REFR_RST  = 8'd2;

	typedef enum logic [0:0] {
		FUNC_TICK  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY     = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_REST      = 2'd2,
		REG_REFR      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DECAY_W-1:0]        decay;
		logic signed [POT_W-1:0]   threshold;
		logic signed [POT_W-1:0]   rest;
		logic [REFR_W-1:0]         refr_ticks;
	} cfg_t;

	typedef struct packed {
		logic                      en;
		logic [WADDR_W-1:0]        addr;
		logic signed [POT_W-1:0]   data;
	} wr_t;

endpackage

// ===== rtl/core/lnl_weight_bank.sv =====
// ----------------------------------------------------------------------------
// lnl_weight_bank
// Synapse weight registers and the per-neuron sum of active input weights.
// ----------------------------------------------------------------------------
module lnl_weight_bank #(
	parameter int INPUT_NEURONS  = 8,
	parameter int OUTPUT_NEURONS = 2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lnl_pkg::wr_t                           wr,
	input  logic [lnl_pkg::SPIKE_IN_W-1:0]         spikes,
	output logic signed [lnl_pkg::SUM_W-1:0]       sums [OUTPUT_NEURONS]
);

	localparam int DEPTH  = INPUT_NEURONS * OUTPUT_NEURONS;
	// only addresses reachable by the index field are stored
	localparam int STORE  = (DEPTH < lnl_pkg::WT_MAX) ? DEPTH : lnl_pkg::WT_MAX;
	localparam int ACT_IN = (INPUT_NEURONS < lnl_pkg::SPIKE_IN_W) ?
	                        INPUT_NEURONS : lnl_pkg::SPIKE_IN_W;

	logic signed [lnl_pkg::POT_W-1:0] w_q  [STORE];
	logic signed [lnl_pkg::SUM_W-1:0] term [OUTPUT_NEURONS][ACT_IN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STORE; k++) begin
				w_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < STORE; k++) begin
				if (wr.en && ({1'b0, wr.addr} == (lnl_pkg::WADDR_W + 1)'(k))) begin
					w_q[k] <= wr.data;
				end
			end
		end
	end

	for (genvar j = 0; j < OUTPUT_NEURONS; j++) begin : g_out
		for (genvar i = 0; i < ACT_IN; i++) begin : g_in
			if (i * OUTPUT_NEURONS + j < STORE) begin : g_used
				assign term[j][i] = spikes[i] ?
					{{(lnl_pkg::SUM_W - lnl_pkg::POT_W){w_q[i*OUTPUT_NEURONS+j][lnl_pkg::POT_W-1]}},
					 w_q[i*OUTPUT_NEURONS+j]} : '0;
			end else begin : g_zero
				assign term[j][i] = '0;
			end
		end

		always_comb begin
			logic signed [lnl_pkg::SUM_W-1:0] acc;
			acc = '0;
			for (int i = 0; i < ACT_IN; i++) begin
				acc = acc + term[j][i];
			end
			sums[j] = acc;
		end
	end

endmodule

// ===== rtl/core/lnl_neuron.sv =====
// ----------------------------------------------------------------------------
// lnl_neuron
// One output neuron: leak, integrate, saturate, fire and refractory count.
// ----------------------------------------------------------------------------
module lnl_neuron (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lnl_pkg::cfg_t                      cfg,
	input  logic                               tick,
	input  logic signed [lnl_pkg::SUM_W-1:0]   syn_sum,
	output logic                               spike
);

	localparam int PROD_W = lnl_pkg::POT_W + lnl_pkg::DECAY_W + 1;
	localparam logic signed [lnl_pkg::ACC_W-1:0] SAT_HI = lnl_pkg::ACC_W'(32767);
	localparam logic signed [lnl_pkg::ACC_W-1:0] SAT_LO = -(lnl_pkg::ACC_W'(32768));

	logic signed [lnl_pkg::POT_W-1:0]  pot_q;
	logic [lnl_pkg::REFR_W-1:0]        refr_q;

	logic signed [PROD_W-1:0]          prod;
	logic signed [lnl_pkg::POT_W-1:0]  leak;
	logic signed [lnl_pkg::ACC_W-1:0]  total;
	logic signed [lnl_pkg::POT_W-1:0]  sat;
	logic                              fire;

	always_comb begin
		prod  = pot_q * $signed({1'b0, cfg.decay});
		// arithmetic shift by 8 gives the floor
		leak  = prod[lnl_pkg::POT_W+lnl_pkg::DECAY_W-1:lnl_pkg::DECAY_W];
		total = {{(lnl_pkg::ACC_W - lnl_pkg::POT_W){leak[lnl_pkg::POT_W-1]}}, leak}
		      + {{(lnl_pkg::ACC_W - lnl_pkg::SUM_W){syn_sum[lnl_pkg::SUM_W-1]}}, syn_sum};
		if (total > SAT_HI) begin
			sat = 16'sh7fff;
		end else if (total < SAT_LO) begin
			sat = 16'sh8000;
		end else begin
			sat = total[lnl_pkg::POT_W-1:0];
		end
		fire  = (refr_q == '0) && (sat > cfg.threshold);
		spike = tick && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_q  <= '0;
			refr_q <= '0;
		end else if (tick) begin
			if (refr_q != '0) begin
				refr_q <= refr_q - 1'b1;
				pot_q  <= cfg.rest;
			end else if (fire) begin
				refr_q <= cfg.refr_ticks;
				pot_q  <= cfg.rest;
			end else begin
				pot_q  <= sat;
			end
		end
	end

endmodule

// ===== rtl/core/lif_neuron_layer_core.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_layer_core
// Layer of leaky integrate-and-fire neurons, Q8.8, stream in / stream out.
// ----------------------------------------------------------------------------
// Accepts one item per cycle. An item is registered on accept and processed
// from that register: a weight write updates the table and gives no result; a
// tick, once the output register is free, updates every neuron and loads the
// spike vector into the output register, which drives m_tvalid. The potential
// update of each neuron (one multiply, an adder tree of up to eight weights
// and a saturate) is combinational. The input stalls only while a result is
// held by m_tready low. Weights reset to zero; configuration takes effect the
// cycle after the write.
module lif_neuron_layer_core #(
	parameter int INPUT_NEURONS  = 8,
	parameter int OUTPUT_NEURONS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] input_spikes, [11:8] weight_index, [27:12] weight_value, zero pad
	input  logic [lnl_pkg::S_TDATA_W-1:0]       s_tdata,
	// [0] func
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] output_spikes, zero pad
	output logic [lnl_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                cfg_we,
	input  logic [lnl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lnl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	lnl_pkg::cfg_t                         cfg_q;

	logic                                  valid_s1;
	lnl_pkg::func_t                        func_s1;
	logic [lnl_pkg::SPIKE_IN_W-1:0]        spikes_s1;
	logic [lnl_pkg::WADDR_W-1:0]           widx_s1;
	logic signed [lnl_pkg::POT_W-1:0]      wval_s1;

	logic                                  m_valid_q;
	logic [lnl_pkg::SPIKE_OUT_W-1:0]       m_spikes_q;

	logic                                  out_free;
	logic                                  go;
	logic                                  tick;
	lnl_pkg::wr_t                          wr;
	logic signed [lnl_pkg::SUM_W-1:0]      sums [OUTPUT_NEURONS];
	logic [OUTPUT_NEURONS-1:0]             spk;
	logic [lnl_pkg::SPIKE_OUT_W-1:0]       spk_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay      <= lnl_pkg::DECAY_RST;
			cfg_q.threshold  <= lnl_pkg::THR_RST;
			cfg_q.rest       <= lnl_pkg::REST_RST;
			cfg_q.refr_ticks <= lnl_pkg::REFR_RST;
		end else if (cfg_we) begin
			case (lnl_pkg::reg_idx_t'(cfg_index))
				lnl_pkg::REG_DECAY:     cfg_q.decay      <= cfg_wdata[lnl_pkg::DECAY_W-1:0];
				lnl_pkg::REG_THRESHOLD: cfg_q.threshold  <= cfg_wdata;
				lnl_pkg::REG_REST:      cfg_q.rest       <= cfg_wdata;
				lnl_pkg::REG_REFR:      cfg_q.refr_ticks <= cfg_wdata[lnl_pkg::REFR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !m_valid_q || m_tready;
	assign go       = valid_s1 && ((func_s1 == lnl_pkg::FUNC_WRITE) || out_free);
	assign s_tready = !valid_s1 || go;
	assign tick     = go && (func_s1 == lnl_pkg::FUNC_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= lnl_pkg::func_t'(s_tuser);
			spikes_s1 <= s_tdata[7:0];
			widx_s1   <= s_tdata[11:8];
			wval_s1   <= s_tdata[27:12];
		end
	end

	always_comb begin
		wr.en   = go && (func_s1 == lnl_pkg::FUNC_WRITE);
		wr.addr = widx_s1;
		wr.data = wval_s1;
	end

	lnl_weight_bank #(
		.INPUT_NEURONS  (INPUT_NEURONS),
		.OUTPUT_NEURONS (OUTPUT_NEURONS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.spikes (spikes_s1),
		.sums   (sums)
	);

	for (genvar j = 0; j < OUTPUT_NEURONS; j++) begin : g_neuron
		lnl_neuron u_neuron (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.tick    (tick),
			.syn_sum (sums[j]),
			.spike   (spk[j])
		);
	end

	always_comb begin
		spk_out = '0;
		for (int b = 0; b < lnl_pkg::SPIKE_OUT_W; b++) begin
			if (b < OUTPUT_NEURONS) begin
				spk_out[b] = spk[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (tick) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			m_spikes_q <= spk_out;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(lnl_pkg::M_TDATA_W - lnl_pkg::SPIKE_OUT_W){1'b0}}, m_spikes_q};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LIF neuron layer core. A short table of directed
// items and register writes exercises reset, weight extremes, refractory
// timing, saturation and extreme settings; then six phases of random weight
// writes and ticks run under several register settings and idle patterns.
// Every tick is predicted by a local copy of the neuron state, and each spike
// vector from the block is compared in order with the predicted one.
// ----------------------------------------------------------------------------
module testbench;

	localparam int N_IN     = lnl_pkg::SPIKE_IN_W;
	localparam int N_OUT    = lnl_pkg::SPIKE_OUT_W;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int N_ROWS   = 34;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t                      kind;
		lnl_pkg::func_t                 func;
		logic [N_IN-1:0]                spk;
		logic [lnl_pkg::WADDR_W-1:0]    widx;
		logic [lnl_pkg::POT_W-1:0]      val;
		lnl_pkg::reg_idx_t              reg_sel;
		logic                           known;
		logic [N_OUT-1:0]               spikes;
	} row_t;

	// known rows carry their spike vector; the others are predicted
	localparam row_t DIRECTED [N_ROWS] = '{
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'hFF, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd0, 16'h7FFF, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h01, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b01},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h01, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h01, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h01, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b1, 2'b01},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd1, 16'h8000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd15, 16'h7FFF, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd14, 16'h8000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h80, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h81, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h81, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		// negative potential leaks toward minus one, as the shift rounds down
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h81, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd2, 16'h7FFF, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd4, 16'h7FFF, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h06, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd3, 16'h8000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_WRITE, 8'h00, 4'd5, 16'h8000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h07, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h07, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		// lowest threshold, no refractory period
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h8000, lnl_pkg::REG_THRESHOLD, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_REFR, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h00FF, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h7FFF, lnl_pkg::REG_REST, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h07, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h8000, lnl_pkg::REG_REST, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h7FFF, lnl_pkg::REG_THRESHOLD, 1'b0, 2'b00},
		'{ROW_CFG, lnl_pkg::FUNC_TICK, 8'h00, 4'd0, 16'h00FF, lnl_pkg::REG_REFR, 1'b0, 2'b00},
		'{ROW_ITEM, lnl_pkg::FUNC_TICK, 8'hFF, 4'd0, 16'h0000, lnl_pkg::REG_DECAY, 1'b0, 2'b00}
	};

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [lnl_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
	logic [0:0]                        s_tuser   = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [lnl_pkg::M_TDATA_W-1:0]     m_tdata;
	logic                              cfg_we    = 1'b0;
	logic [lnl_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [lnl_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

	// local copy of the layer
	logic [lnl_pkg::DECAY_W-1:0]       cur_decay;
	logic signed [lnl_pkg::POT_W-1:0]  cur_thr;
	logic signed [lnl_pkg::POT_W-1:0]  cur_rest;
	logic [lnl_pkg::REFR_W-1:0]        cur_refr;
	logic signed [lnl_pkg::POT_W-1:0]  potential [N_OUT];
	logic [lnl_pkg::REFR_W-1:0]        silent_left [N_OUT];
	logic signed [lnl_pkg::POT_W-1:0]  weights [lnl_pkg::WT_MAX];

	logic [N_OUT-1:0] spike_q [$];
	logic [N_OUT-1:0] exp_spikes;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int ticks_sent;
	int writes_sent;
	int results_checked;
	int fired_bits;
	int reg_writes;

	lnl_pkg::cfg_t phase_cfg [N_PHASES];

	lif_neuron_layer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("lif_neuron_layer_core verification failed");
		$finish;
	end

	function automatic logic [N_OUT-1:0] integrate_and_fire(input logic [N_IN-1:0] spk);
		int acc;
		logic [N_OUT-1:0] fired;
		fired = '0;
		for (int j = 0; j < N_OUT; j++) begin
			if (silent_left[j] != '0) begin
				silent_left[j] = silent_left[j] - 1'b1;
				potential[j] = cur_rest;
			end else begin
				acc = (int'(potential[j]) * int'(cur_decay)) >>> 8;
				for (int i = 0; i < N_IN; i++) begin
					if (spk[i])
						acc = acc + int'(weights[i * N_OUT + j]);
				end
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				if (acc > int'(cur_thr)) begin
					fired[j] = 1'b1;
					potential[j] = cur_rest;
					silent_left[j] = cur_refr;
				end else begin
					potential[j] = acc[lnl_pkg::POT_W-1:0];
				end
			end
		end
		return fired;
	endfunction

	task automatic send_item(input lnl_pkg::func_t f, input logic [N_IN-1:0] spk,
			input logic [lnl_pkg::WADDR_W-1:0] widx, input logic [lnl_pkg::POT_W-1:0] wval,
			input logic given, input logic [N_OUT-1:0] given_spikes);
		logic [N_OUT-1:0] predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {4'h0, wval, widx, spk};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		if (f == lnl_pkg::FUNC_WRITE) begin
			weights[widx] = wval;
			writes_sent++;
		end else begin
			predicted = integrate_and_fire(spk);
			spike_q.push_back(given ? given_spikes : predicted);
			ticks_sent++;
		end
	endtask

	// stop sending and let the block go quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (spike_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input lnl_pkg::reg_idx_t r,
			input logic [lnl_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= d;
		case (r)
			lnl_pkg::REG_DECAY:     cur_decay = d[lnl_pkg::DECAY_W-1:0];
			lnl_pkg::REG_THRESHOLD: cur_thr   = d;
			lnl_pkg::REG_REST:      cur_rest  = d;
			lnl_pkg::REG_REFR:      cur_refr  = d[lnl_pkg::REFR_W-1:0];
			default:                ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (spike_q.size() == 0) begin
				$error("output_spikes: expected none, got %b", m_tdata[N_OUT-1:0]);
				fail_count++;
			end else begin
				exp_spikes = spike_q.pop_front();
				results_checked++;
				fired_bits += $countones(m_tdata[N_OUT-1:0]);
				if (m_tdata[N_OUT-1:0] !== exp_spikes) begin
					$error("output_spikes: expected %b, got %b",
						exp_spikes, m_tdata[N_OUT-1:0]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [N_IN-1:0]              spk;
		logic [lnl_pkg::POT_W-1:0]    wval;
		row_t                         row;

		cur_decay = lnl_pkg::DECAY_RST;
		cur_thr   = lnl_pkg::THR_RST;
		cur_rest  = lnl_pkg::REST_RST;
		cur_refr  = lnl_pkg::REFR_RST;
		for (int k = 0; k < N_OUT; k++) begin
			potential[k]   = '0;
			silent_left[k] = '0;
		end
		for (int k = 0; k < lnl_pkg::WT_MAX; k++)
			weights[k] = '0;
		fail_count      = 0;
		ticks_sent      = 0;
		writes_sent     = 0;
		results_checked = 0;
		fired_bits      = 0;
		reg_writes      = 0;
		send_idle_pct   = 26;
		recv_idle_pct   = 76;

		phase_cfg[0] = '{lnl_pkg::DECAY_RST, lnl_pkg::THR_RST, lnl_pkg::REST_RST,
			lnl_pkg::REFR_RST};
		phase_cfg[1] = '{8'd255, 16'h8000, 16'h7FFF, 8'd0};
		phase_cfg[2] = '{8'd0, 16'h7FFE, 16'h8000, 8'd255};
		phase_cfg[3] = '{8'($urandom), 16'($urandom_range(0, 3071) - 1024),
			16'($urandom_range(0, 1023) - 512), 8'($urandom_range(0, 7))};
		phase_cfg[4] = '{8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)};
		phase_cfg[5] = '{8'd200, 16'sd512, -16'sd256, 8'd1};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.reg_sel, row.val);
			end else begin
				send_item(row.func, row.spk, row.widx, row.val, row.known, row.spikes);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_reg(lnl_pkg::REG_DECAY,     {8'h00, phase_cfg[p].decay});
			write_reg(lnl_pkg::REG_THRESHOLD, phase_cfg[p].threshold);
			write_reg(lnl_pkg::REG_REST,      phase_cfg[p].rest);
			write_reg(lnl_pkg::REG_REFR,      {8'h00, phase_cfg[p].refr_ticks});
			case (p / 2)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 99) < 80)
						wval = 16'($urandom_range(0, 1535) - 512);
					else
						wval = 16'($urandom);
					send_item(lnl_pkg::FUNC_WRITE, 8'($urandom),
						4'($urandom_range(0, lnl_pkg::WT_MAX - 1)), wval, 1'b0, '0);
				end else begin
					if ($urandom_range(0, 99) < 70)
						spk = 8'($urandom);
					else
						spk = 8'($urandom) & 8'($urandom);
					send_item(lnl_pkg::FUNC_TICK, spk, 4'($urandom), 16'($urandom),
						1'b0, '0);
				end
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (spike_q.size() != 0) begin
			$error("output_spikes: %0d expected results never arrived", spike_q.size());
			fail_count++;
		end
		$display("Covered %0d ticks and %0d weight writes over %0d register writes;",
			ticks_sent, writes_sent, reg_writes);
		$display("%0d spike vectors compared, %0d neuron firings seen, %0d failures.",
			results_checked, fired_bits, fail_count);
		if (fail_count == 0)
			$display("lif_neuron_layer_core verification clean");
		else
			$display("lif_neuron_layer_core verification failed");
		$finish;
	end

endmodule
